/* src/srrw_pkg.sv */
package srrw_pkg;

	// Field widths fixed by the frame format
	localparam int SEQ_W = 7;
	localparam int WIN_W = 7;

	// Defaults
	localparam int SEQ_SPACE_DEF = 128;
	localparam logic [WIN_W-1:0] WIN_RESET = 7'd5;

	// ack_kind codes
	localparam logic ACK_NEW    = 1'b0;
	localparam logic ACK_REPEAT = 1'b1;

endpackage

/* src/selective_repeat_receiver_window_top.sv */
// Selective-repeat ARQ receiver window. Pulse start with seq_num while busy is low. The
// block folds multiples of SEQ_SPACE out of seq_num when SEQ_SPACE is below 128, takes
// the offset from the window base and checks it against the window. A frame outside the
// window ends there; one inside it is marked and the window base slides over the marks.
// Busy stays high meanwhile. The slide reads one mark per cycle from the mark memory. A
// result is shown on ack_num/ack_kind/window_base for exactly one cycle with result_valid
// high; the receiver cannot stall it. A repeat of a frame already marked in the window
// gives no result. After reset the block clears its mark memory with busy high.
// The window width is written through cfg_valid/cfg_data; cfg_ready is high only while the
// block is idle, so a new width never lands on an item in flight.
module selective_repeat_receiver_window_top
	import srrw_pkg::*;
#(
	parameter int SEQ_SPACE = SEQ_SPACE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [SEQ_W-1:0] seq_num,
	output logic             result_valid,
	output logic [SEQ_W-1:0] ack_num,
	output logic             ack_kind,
	output logic [SEQ_W-1:0] window_base,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [WIN_W-1:0] cfg_data
);

	localparam int IW = $clog2(SEQ_SPACE);
	localparam int AW = (IW > SEQ_W) ? IW : SEQ_W;
	localparam logic [AW:0] SPACE_A = (AW+1)'(SEQ_SPACE);
	localparam logic [AW:0] HALF_A  = (AW+1)'(SEQ_SPACE / 2);
	localparam logic [IW-1:0] LAST_IDX = IW'(SEQ_SPACE - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REDUCE,
		ST_OFFS,
		ST_WIN,
		ST_MARK,
		ST_SLIDE
	} state_t;

	state_t          state_q;
	logic [IW-1:0]   clr_q;
	logic [AW-1:0]   seq_q;
	logic [IW-1:0]   base_q;
	logic [AW:0]     off_q;
	logic            borrow_q;
	logic            in_win_q;
	logic            fresh_q;
	logic            fwd_q;
	logic [WIN_W-1:0] win_q;
	logic            result_valid_q;
	logic [SEQ_W-1:0] ack_num_q;
	logic            ack_kind_q;
	logic [SEQ_W-1:0] window_base_q;

	// mark memory
	logic            mark_mem [SEQ_SPACE];
	logic            rd_data_q;
	logic [IW-1:0]   rd_addr;
	logic            mem_we;
	logic [IW-1:0]   mem_wa;
	logic            mem_wd;

	// shared add/subtract unit
	logic [AW:0]     alu_a;
	logic [AW:0]     alu_b;
	logic            alu_sub;
	logic [AW:0]     alu_y;

	logic [IW-1:0]   seq_idx;
	logic [AW:0]     eff_win;
	logic [IW-1:0]   base_inc;
	logic [IW-1:0]   base_dec;
	logic            mark_now;

	assign seq_idx  = seq_q[IW-1:0];
	assign eff_win  = ((AW+1)'(win_q) > HALF_A) ? HALF_A : (AW+1)'(win_q);
	assign base_dec = (base_q == '0) ? LAST_IDX : base_q - 1'b1;
	assign base_inc = (alu_y == SPACE_A) ? '0 : alu_y[IW-1:0];
	assign mark_now = rd_data_q | fwd_q;

	// operand selection for the shared unit
	always_comb begin
		alu_a   = (AW+1)'(seq_q);
		alu_b   = SPACE_A;
		alu_sub = 1'b1;
		case (state_q)
			ST_REDUCE: begin
				alu_a   = (AW+1)'(seq_q);
				alu_b   = SPACE_A;
				alu_sub = 1'b1;
			end
			ST_OFFS: begin
				alu_a   = (AW+1)'(seq_q);
				alu_b   = (AW+1)'(base_q);
				alu_sub = 1'b1;
			end
			ST_WIN: begin
				alu_a   = off_q;
				alu_b   = borrow_q ? SPACE_A : '0;
				alu_sub = 1'b0;
			end
			ST_SLIDE: begin
				alu_a   = (AW+1)'(base_q);
				alu_b   = (AW+1)'(1);
				alu_sub = 1'b0;
			end
			default: begin
				alu_a   = (AW+1)'(seq_q);
				alu_b   = SPACE_A;
				alu_sub = 1'b1;
			end
		endcase
	end

	assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

	// memory port control
	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = seq_idx;
		mem_wd  = 1'b0;
		rd_addr = seq_idx;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = 1'b0;
			end
			ST_MARK: begin
				mem_we  = in_win_q & ~rd_data_q;
				mem_wa  = seq_idx;
				mem_wd  = 1'b1;
				rd_addr = base_q;
			end
			ST_SLIDE: begin
				mem_we  = mark_now;
				mem_wa  = base_q;
				mem_wd  = 1'b0;
				rd_addr = base_inc;
			end
			default: begin
				rd_addr = seq_idx;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mark_mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mark_mem[rd_addr];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			win_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			seq_q          <= '0;
			base_q         <= '0;
			off_q          <= '0;
			borrow_q       <= 1'b0;
			in_win_q       <= 1'b0;
			fresh_q        <= 1'b0;
			fwd_q          <= 1'b0;
			result_valid_q <= 1'b0;
			ack_num_q      <= '0;
			ack_kind_q     <= ACK_NEW;
			window_base_q  <= '0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						seq_q   <= AW'(seq_num);
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					// fold out multiples of the sequence space
					if (!alu_y[AW]) begin
						seq_q <= alu_y[AW-1:0];
					end else begin
						state_q <= ST_OFFS;
					end
				end
				ST_OFFS: begin
					off_q    <= alu_y;
					borrow_q <= alu_y[AW];
					state_q  <= ST_WIN;
				end
				ST_WIN: begin
					in_win_q <= (alu_y < eff_win);
					state_q  <= ST_MARK;
				end
				ST_MARK: begin
					if (!in_win_q) begin
						result_valid_q <= 1'b1;
						ack_num_q      <= SEQ_W'(base_dec);
						ack_kind_q     <= ACK_REPEAT;
						window_base_q  <= SEQ_W'(base_q);
						state_q        <= ST_IDLE;
					end else begin
						fresh_q <= ~rd_data_q;
						// read of base misses a write to the same entry
						fwd_q   <= ~rd_data_q && (seq_idx == base_q);
						state_q <= ST_SLIDE;
					end
				end
				ST_SLIDE: begin
					fwd_q <= 1'b0;
					if (mark_now) begin
						base_q <= base_inc;
					end else begin
						result_valid_q <= fresh_q;
						ack_num_q      <= SEQ_W'(seq_idx);
						ack_kind_q     <= ACK_NEW;
						window_base_q  <= SEQ_W'(base_q);
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign cfg_ready    = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign ack_num      = ack_num_q;
	assign ack_kind     = ack_kind_q;
	assign window_base  = window_base_q;

	// checks
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_start_to_reduce: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_REDUCE))
		else $error("accepted item did not enter sequencer");

	a_new_from_slide: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (ack_kind == ACK_NEW)) |-> ($past(state_q) == ST_SLIDE))
		else $error("new-frame ack not issued at end of slide");

	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		base_q <= LAST_IDX)
		else $error("window base outside sequence space");

	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result shown while sequencer busy");

endmodule
